### design/rth_pkg.sv
// Package for the range threshold histogram block.
// Holds widths, register codes, reset values and the configuration struct.
// No dependencies.
package rth_pkg;

   localparam int MAX_THRESHOLDS = 7;
   localparam int COUNT_WIDTH    = 16;
   localparam int RANGE_WIDTH    = 20;

   // Fixed field widths of the ports
   localparam int RANGE_FIELD_WIDTH = 20;
   localparam int THR_WIDTH         = 20;
   localparam int TCOUNT_WIDTH      = 3;
   localparam int BIN_FIELD_WIDTH   = 3;
   localparam int COUNT_FIELD_WIDTH = 16;
   localparam int NUM_THR_REGS      = 7;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int N_BINS        = MAX_THRESHOLDS + 1;
   localparam int BIN_IDX_WIDTH = (N_BINS > 1) ? $clog2(N_BINS) : 1;
   localparam int CMP_WIDTH     = (RANGE_WIDTH > THR_WIDTH) ? RANGE_WIDTH : THR_WIDTH;

   localparam logic [NUM_THR_REGS-1:0][THR_WIDTH-1:0] THR_RESET = {
      20'd1048575, 20'd1048575, 20'd1048575, 20'd25000, 20'd4000, 20'd1000, 20'd350
   };
   localparam logic [TCOUNT_WIDTH-1:0] TCOUNT_RESET = 3'd4;

   typedef enum logic [2:0] {
      REG_THRESHOLD_0,
      REG_THRESHOLD_1,
      REG_THRESHOLD_2,
      REG_THRESHOLD_3,
      REG_THRESHOLD_4,
      REG_THRESHOLD_5,
      REG_THRESHOLD_6,
      REG_THRESHOLD_COUNT
   } reg_index_type;

   typedef struct packed {
      logic [NUM_THR_REGS-1:0][THR_WIDTH-1:0] threshold;
      logic [TCOUNT_WIDTH-1:0]                threshold_count;
   } cfg_type;

endpackage

### design/rth_if.sv
// Channel interfaces for the range threshold histogram block.
// rth_req_if carries range samples, rth_rsp_if carries bin results.
// Depends on rth_pkg.
interface rth_req_if;
   import rth_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [RANGE_FIELD_WIDTH-1:0] range_mm;
   logic                         range_invalid;
   logic                         scan_end;

   modport source (output valid, output range_mm, output range_invalid, output scan_end,
                   input ready);
   modport sink (input valid, input range_mm, input range_invalid, input scan_end,
                 output ready);
endinterface

interface rth_rsp_if;
   import rth_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [BIN_FIELD_WIDTH-1:0]   bin_index;
   logic [COUNT_FIELD_WIDTH-1:0] bin_count;
   logic [RANGE_FIELD_WIDTH-1:0] scan_minimum;
   logic [RANGE_FIELD_WIDTH-1:0] scan_maximum;
   logic                         no_valid_sample;
   logic                         last_bin;

   modport source (output valid, output bin_index, output bin_count, output scan_minimum,
                   output scan_maximum, output no_valid_sample, output last_bin,
                   input ready);
   modport sink (input valid, input bin_index, input bin_count, input scan_minimum,
                 input scan_maximum, input no_valid_sample, input last_bin,
                 output ready);
endinterface

### design/rth_csr.sv
// APB-style register file for the range threshold histogram block.
// Holds the bin thresholds and the threshold count. Depends on rth_pkg.
module rth_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rth_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rth_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rth_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready,
   output rth_pkg::cfg_type                   cfg
);
   import rth_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_THRESHOLD_0:     cfg_in.threshold[0] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_1:     cfg_in.threshold[1] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_2:     cfg_in.threshold[2] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_3:     cfg_in.threshold[3] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_4:     cfg_in.threshold[4] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_5:     cfg_in.threshold[5] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_6:     cfg_in.threshold[6] = csr_pwdata[THR_WIDTH-1:0];
            REG_THRESHOLD_COUNT: cfg_in.threshold_count = csr_pwdata[TCOUNT_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_THRESHOLD_0:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[0]);
         REG_THRESHOLD_1:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[1]);
         REG_THRESHOLD_2:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[2]);
         REG_THRESHOLD_3:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[3]);
         REG_THRESHOLD_4:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[4]);
         REG_THRESHOLD_5:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[5]);
         REG_THRESHOLD_6:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold[6]);
         REG_THRESHOLD_COUNT: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.threshold_count);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold       <= THR_RESET;
         cfg_ff.threshold_count <= TCOUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/range_threshold_histogram_unit.sv
// Top level of the range threshold histogram block: per-sample bin counting,
// scan min/max tracking and result drain. Depends on rth_pkg, rth_if, rth_csr.
//
// Takes one range sample per clock. Every sample is compared against all
// thresholds in parallel and the live bin counters, minimum and maximum are
// updated in the cycle it is accepted. A sample marked scan_end copies the
// finished histogram into a result bank and clears the live counters, so the
// next scan starts counting at once. The bank then delivers one result word
// per cycle while rsp.ready is high, threshold_count + 1 words per scan (none
// when the count is zero). A further scan_end sample waits on the request
// channel until the bank has delivered its last word; ordinary samples keep
// flowing meanwhile, and only the scan_end sample is held.
// Configuration registers hold their values through reset-free operation and
// take effect from the next accepted sample.
module range_threshold_histogram_unit (
   input  logic                               clock,
   input  logic                               reset,
   rth_req_if.sink                            req,
   rth_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rth_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rth_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rth_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import rth_pkg::*;

   cfg_type cfg;

   // Live scan state
   logic [COUNT_WIDTH-1:0] count_ff [N_BINS];
   logic [COUNT_WIDTH-1:0] count_in [N_BINS];
   logic [RANGE_WIDTH-1:0] min_ff, min_in;
   logic [RANGE_WIDTH-1:0] max_ff, max_in;
   logic                   seen_ff, seen_in;

   // Result bank
   logic [COUNT_WIDTH-1:0]   snap_count_ff [N_BINS];
   logic [RANGE_WIDTH-1:0]   snap_min_ff;
   logic [RANGE_WIDTH-1:0]   snap_max_ff;
   logic                     snap_seen_ff;
   logic [BIN_IDX_WIDTH-1:0] snap_last_ff;
   logic                     busy_ff, busy_in;
   logic [BIN_IDX_WIDTH-1:0] idx_ff, idx_in;

   logic                     accept;
   logic                     sample_ok;
   logic                     load_bank;
   logic                     rsp_take;
   logic [BIN_IDX_WIDTH-1:0] used_thr;
   logic [RANGE_WIDTH-1:0]   range_val;
   logic [N_BINS-1:0]        le;
   logic [N_BINS-1:0]        hit;

   rth_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Hold a new scan_end until the bank has drained
   assign req.ready = !(busy_ff && req.scan_end);
   assign accept    = req.valid && req.ready;

   assign used_thr  = (cfg.threshold_count > TCOUNT_WIDTH'(MAX_THRESHOLDS))
                      ? BIN_IDX_WIDTH'(MAX_THRESHOLDS)
                      : BIN_IDX_WIDTH'(cfg.threshold_count);
   assign range_val = RANGE_WIDTH'(req.range_mm);
   assign sample_ok = accept && !req.range_invalid && (used_thr != '0);
   assign load_bank = accept && req.scan_end && (used_thr != '0);

   for (genvar k = 0; k < N_BINS; k++) begin : g_bin
      if (k < MAX_THRESHOLDS) begin : g_le
         assign le[k] = CMP_WIDTH'(range_val) <= CMP_WIDTH'(cfg.threshold[k]);
      end else begin : g_top
         assign le[k] = 1'b0;
      end

      if (k == 0) begin : g_first
         assign hit[k] = sample_ok && le[0];
      end else begin : g_rest
         // Middle bin is bounded on both sides, the top bin only below
         assign hit[k] = sample_ok &&
                         (((BIN_IDX_WIDTH'(k) < used_thr) && !le[k-1] && le[k]) ||
                          ((BIN_IDX_WIDTH'(k) == used_thr) && !le[k-1]));
      end

      always_comb begin
         count_in[k] = count_ff[k];
         if (hit[k] && (count_ff[k] != {COUNT_WIDTH{1'b1}})) begin
            count_in[k] = count_ff[k] + COUNT_WIDTH'(1);
         end
      end
   end

   always_comb begin
      min_in  = min_ff;
      max_in  = max_ff;
      seen_in = seen_ff || sample_ok;
      if (sample_ok && (range_val < min_ff)) begin
         min_in = range_val;
      end
      if (sample_ok && (range_val > max_ff)) begin
         max_in = range_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.scan_end)) begin
         for (int k = 0; k < N_BINS; k++) begin
            count_ff[k] <= '0;
         end
         min_ff  <= {RANGE_WIDTH{1'b1}};
         max_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         seen_ff  <= seen_in;
      end
   end

   // Bank payload: capture the histogram including the closing sample
   always_ff @(posedge clock) begin
      if (load_bank) begin
         snap_count_ff <= count_in;
         snap_min_ff   <= min_in;
         snap_max_ff   <= max_in;
         snap_seen_ff  <= seen_in;
         snap_last_ff  <= used_thr;
      end
   end

   assign rsp_take = rsp.valid && rsp.ready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      priority if (load_bank) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_take) begin
         if (idx_ff == snap_last_ff) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + BIN_IDX_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign rsp.valid           = busy_ff;
   assign rsp.bin_index       = BIN_FIELD_WIDTH'(idx_ff);
   assign rsp.bin_count       = COUNT_FIELD_WIDTH'(snap_count_ff[idx_ff]);
   assign rsp.scan_minimum    = snap_seen_ff ? RANGE_FIELD_WIDTH'(snap_min_ff) : '0;
   assign rsp.scan_maximum    = snap_seen_ff ? RANGE_FIELD_WIDTH'(snap_max_ff) : '0;
   assign rsp.no_valid_sample = !snap_seen_ff;
   assign rsp.last_bin        = (idx_ff == snap_last_ff);

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= snap_last_ff))
      else $error("result index past last bin");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.scan_end) |-> !busy_ff)
      else $error("scan end taken while results still pending");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_bin) |=> !rsp.valid)
      else $error("results continue after last bin");

   a_empty_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.no_valid_sample) |->
         ((rsp.scan_minimum == '0) && (rsp.scan_maximum == '0)))
      else $error("min/max nonzero for empty scan");
`endif

endmodule

### tb/sv/rth_histogram_checker.sv
// Checker for the range threshold histogram unit: mirrors the registers from
// the APB port, predicts the bin words of every scan and compares reads and results.
// Depends on rth_pkg and the channel interfaces rth_req_if / rth_rsp_if.
module rth_histogram_checker (
   input  logic                               clock,
   input  logic                               reset,
   rth_req_if                                 req_mon,
   rth_rsp_if                                 rsp_mon,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rth_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rth_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [rth_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   input  logic                               csr_pready,
   output int                                 mismatch_total,
   output int                                 pending_words,
   output int                                 checked_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import rth_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [BIN_FIELD_WIDTH-1:0]   bin_index;
      logic [COUNT_FIELD_WIDTH-1:0] bin_count;
      logic [RANGE_FIELD_WIDTH-1:0] scan_minimum;
      logic [RANGE_FIELD_WIDTH-1:0] scan_maximum;
      logic                         no_valid_sample;
      logic                         last_bin;
   } bin_word_type;

   cfg_type                   cfg_shadow;
   logic [COUNT_WIDTH-1:0]    bin_tally [N_BINS];
   logic [RANGE_WIDTH-1:0]    scan_low;
   logic [RANGE_WIDTH-1:0]    scan_high;
   logic                      scan_has_valid;
   bin_word_type              expected_words [$];
   bin_word_type              got_word;
   bin_word_type              want_word;
   reg_index_type             csr_reg;
   logic [CSR_DATA_WIDTH-1:0] csr_expect;
   int                        mismatches;
   int                        words_seen;

   function automatic string describe_word(bin_word_type w);
      return $sformatf("bin %0d count %0d min %0d max %0d no_valid %0b last %0b",
                       w.bin_index, w.bin_count, w.scan_minimum, w.scan_maximum,
                       w.no_valid_sample, w.last_bin);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("[%0t] MISMATCH %s", $realtime, what);
      end
   endtask

   task automatic clear_scan_state();
      int b;
      for (b = 0; b < N_BINS; b++) begin
         bin_tally[b] = '0;
      end
      scan_low       = '1;
      scan_high      = '0;
      scan_has_valid = 1'b0;
   endtask

   task automatic bump_bin(input int b);
      if (bin_tally[b] != '1) begin
         bin_tally[b] = bin_tally[b] + 1'b1;
      end
   endtask

   task automatic tally_sample(input logic [RANGE_FIELD_WIDTH-1:0] sample_range,
                               input logic sample_invalid, input logic sample_last);
      int                     used;
      int                     k;
      logic [RANGE_WIDTH-1:0] r;
      bin_word_type           w;
      used = int'(cfg_shadow.threshold_count);
      if (used > MAX_THRESHOLDS) begin
         used = MAX_THRESHOLDS;
      end
      r = sample_range[RANGE_WIDTH-1:0];
      // every bin is tested on its own: unordered thresholds may hit several or none
      if (used > 0 && !sample_invalid) begin
         if (r <= cfg_shadow.threshold[0]) begin
            bump_bin(0);
         end
         for (k = 1; k < used; k++) begin
            if (r > cfg_shadow.threshold[k-1] && r <= cfg_shadow.threshold[k]) begin
               bump_bin(k);
            end
         end
         if (r > cfg_shadow.threshold[used-1]) begin
            bump_bin(used);
         end
         if (r < scan_low) begin
            scan_low = r;
         end
         if (r > scan_high) begin
            scan_high = r;
         end
         scan_has_valid = 1'b1;
      end
      if (sample_last) begin
         for (k = 0; used > 0 && k <= used; k++) begin
            w.bin_index       = k[BIN_FIELD_WIDTH-1:0];
            w.bin_count       = bin_tally[k];
            w.scan_minimum    = scan_has_valid ? scan_low : '0;
            w.scan_maximum    = scan_has_valid ? scan_high : '0;
            w.no_valid_sample = !scan_has_valid;
            w.last_bin        = (k == used);
            expected_words.insert(expected_words.size(), w);
         end
         clear_scan_state();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_shadow.threshold       = THR_RESET;
         cfg_shadow.threshold_count = TCOUNT_RESET;
         clear_scan_state();
         expected_words.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            tally_sample(req_mon.range_mm, req_mon.range_invalid, req_mon.scan_end);
         end

         if (csr_psel && csr_penable && csr_pready) begin
            csr_reg    = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
            csr_expect = '0;
            if (csr_reg == REG_THRESHOLD_COUNT) begin
               csr_expect[TCOUNT_WIDTH-1:0] = cfg_shadow.threshold_count;
            end else begin
               csr_expect[THR_WIDTH-1:0] = cfg_shadow.threshold[int'(csr_reg)];
            end
            if (csr_pwrite) begin
               if (csr_reg == REG_THRESHOLD_COUNT) begin
                  cfg_shadow.threshold_count = csr_pwdata[TCOUNT_WIDTH-1:0];
               end else begin
                  cfg_shadow.threshold[int'(csr_reg)] = csr_pwdata[THR_WIDTH-1:0];
               end
            end else if (csr_prdata !== csr_expect) begin
               report_mismatch($sformatf("register %s read: expected 0x%0h, got 0x%0h",
                                         csr_reg.name(), csr_expect, csr_prdata));
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got_word = {rsp_mon.bin_index, rsp_mon.bin_count, rsp_mon.scan_minimum,
                        rsp_mon.scan_maximum, rsp_mon.no_valid_sample, rsp_mon.last_bin};
            words_seen++;
            if (expected_words.size() == 0) begin
               report_mismatch({"bin word with none expected: ", describe_word(got_word)});
            end else begin
               want_word = expected_words.pop_front();
               if (got_word !== want_word) begin
                  report_mismatch({"bin word: expected ", describe_word(want_word),
                                   " / got ", describe_word(got_word)});
               end
            end
         end
      end

      mismatch_total <= mismatches;
      pending_words  <= expected_words.size();
      checked_words  <= words_seen;
   end

endmodule

### tb/sv/tb_range_threshold_histogram_unit.sv
// Testbench top for the range threshold histogram unit: clock, reset, APB
// programming, sample and result-side traffic, verdict. Depends on rth_pkg,
// rth_if, the unit itself and rth_histogram_checker.
module tb_range_threshold_histogram_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rth_pkg::*;

   localparam int RANGE_MAX        = (1 << RANGE_FIELD_WIDTH) - 1;
   localparam int PHASE_ITEMS      = 30;
   localparam int RANDOM_PHASES    = 8;
   localparam int LONG_HOLD        = 300;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LIMIT_CYCLES     = 500000;

   typedef logic [RANGE_FIELD_WIDTH-1:0] range_word_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int mismatch_total;
   int pending_words;
   int checked_words;
   int cycle_count = 0;
   int samples_sent = 0;
   int scans_sent = 0;
   int holds_asked = 0;
   int holds_done = 0;
   bit no_idle = 1'b0;

   logic [THR_WIDTH-1:0] thr_now [NUM_THR_REGS];

   rth_req_if req_ch ();
   rth_rsp_if rsp_ch ();

   range_threshold_histogram_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rth_histogram_checker hist_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_total (mismatch_total),
      .pending_words  (pending_words),
      .checked_words  (checked_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d bin words still due", cycle_count,
                  pending_words);
         $display("range_threshold_histogram_unit regression: fail");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic range_word_type pick_range();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return thr_now[$urandom_range(0, NUM_THR_REGS-1)]
                            + range_word_type'($urandom_range(0, 2)) - range_word_type'(1);
         default:    return range_word_type'($urandom);
      endcase
   endfunction

   // Result side: random stalls per word, plus a long hold when asked.
   initial begin
      int wait_cycles;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_asked > holds_done) begin
            holds_done++;
            wait_cycles = LONG_HOLD;
         end else begin
            wait_cycles = draw_gap();
         end
         repeat (wait_cycles) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_sample(input range_word_type sample_range, input logic sample_invalid,
                              input logic sample_last);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.range_mm      <= sample_range;
      req_ch.range_invalid <= sample_invalid;
      req_ch.scan_end      <= sample_last;
      do @(posedge clock); while (!req_ch.ready);
      samples_sent++;
      if (sample_last) begin
         scans_sent++;
      end
   endtask

   task automatic send_scan(input int scan_len, input bit all_invalid);
      int i;
      for (i = 0; i < scan_len; i++) begin
         send_sample(pick_range(), all_invalid || ($urandom_range(0, 7) == 0),
                     i == scan_len - 1);
      end
   endtask

   // Drop valid, wait for every due word, then let the drain pipeline empty.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input reg_index_type idx,
                             input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic readback_registers();
      int i;
      for (i = 0; i <= int'(REG_THRESHOLD_COUNT); i++) begin
         csr_access(1'b0, reg_index_type'(i), '0);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_histogram(input logic [TCOUNT_WIDTH-1:0] new_count);
      int i;
      for (i = 0; i < NUM_THR_REGS; i++) begin
         csr_access(1'b1, reg_index_type'(i), CSR_DATA_WIDTH'(thr_now[i]));
      end
      csr_access(1'b1, REG_THRESHOLD_COUNT, CSR_DATA_WIDTH'(new_count));
      readback_registers();
   endtask

   initial begin
      int                      phase;
      int                      i;
      int                      level;
      int                      step_cap;
      int                      phase_start;
      logic [TCOUNT_WIDTH-1:0] new_count;
      int                      edge_ranges [10];

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.range_mm      <= '0;
      req_ch.range_invalid <= 1'b0;
      req_ch.scan_end      <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      for (i = 0; i < NUM_THR_REGS; i++) begin
         thr_now[i] = THR_RESET[i];
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      readback_registers();

      // Bin edges at the reset thresholds, infinity, a NaN, then a scan with no valid range.
      edge_ranges = '{0, 350, 351, 1000, 1001, 4000, 4001, 25000, 25001, RANGE_MAX};
      for (i = 0; i < 10; i++) begin
         send_sample(range_word_type'(edge_ranges[i]), 1'b0, 1'b0);
      end
      send_sample(range_word_type'(7), 1'b1, 1'b0);
      send_sample(range_word_type'(12345), 1'b0, 1'b1);
      send_sample('0, 1'b1, 1'b0);
      send_sample('1, 1'b1, 1'b1);

      // Raise the threshold count in the middle of a scan.
      send_sample(range_word_type'(500), 1'b0, 1'b0);
      send_sample(range_word_type'(30000), 1'b0, 1'b0);
      settle_block();
      program_histogram(3'd7);
      send_sample('1, 1'b0, 1'b0);
      send_sample(range_word_type'(2000), 1'b0, 1'b1);

      // No thresholds: the scan is dropped without words.
      settle_block();
      program_histogram(3'd0);
      send_sample(range_word_type'(100), 1'b0, 1'b0);
      send_sample(range_word_type'(200), 1'b0, 1'b1);
      settle_block();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle  = (phase == 3) || (phase == 6);
         step_cap = $urandom_range(0, 1) ? 300000 : 3000;
         level    = 0;
         for (i = 0; i < NUM_THR_REGS; i++) begin
            case (phase)
               2:       thr_now[i] = '0;
               3:       thr_now[i] = '1;
               4, 7:    thr_now[i] = range_word_type'($urandom);
               default: begin
                  level      = level + $urandom_range(0, step_cap);
                  thr_now[i] = (level > RANGE_MAX) ? '1 : range_word_type'(level);
               end
            endcase
         end
         case (phase)
            0, 2, 3: new_count = 3'd7;
            1:       new_count = 3'd1;
            5:       new_count = 3'd0;
            6:       new_count = 3'd3;
            default: new_count = TCOUNT_WIDTH'($urandom_range(0, 7));
         endcase
         program_histogram(new_count);
         // short scans under a long result stall back up into the sample channel
         if (phase == 6) begin
            holds_asked++;
         end
         phase_start = samples_sent;
         while (samples_sent - phase_start < PHASE_ITEMS) begin
            send_scan((phase == 6) ? $urandom_range(1, 2) : $urandom_range(1, 12),
                      $urandom_range(0, 9) == 0);
         end
         settle_block();
      end

      $display("Covered %0d samples in %0d scans, %0d bin words checked, over %0d setups",
               samples_sent, scans_sent, checked_words, RANDOM_PHASES + 3);
      $display("including zero and full thresholds, NaN-only scans and %0d", holds_done);
      $display("long result-side stalls.");
      if (mismatch_total == 0) begin
         $display("range_threshold_histogram_unit regression: pass");
      end else begin
         $display("%0d mismatches", mismatch_total);
         $display("range_threshold_histogram_unit regression: fail");
      end
      $finish;
   end

endmodule
